[rtl/ils_pkg.sv]
package ils_pkg;

   localparam int CAPACITY = 64;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   localparam int OP_W     = 3;
   localparam int POS_W    = 7;
   localparam int DATA_W   = 32;
   localparam int STAT_W   = 2;
   localparam int CNTO_W   = 7;
   localparam int CMP_W    = (POS_W > CNT_W) ? POS_W : CNT_W;

   localparam int REQ_W    = ((OP_W + POS_W + DATA_W + 7) / 8) * 8;
   localparam int RSP_W    = ((DATA_W + STAT_W + CNTO_W + 7) / 8) * 8;

   typedef enum logic [OP_W-1:0] {
      OP_READ     = 3'd0,
      OP_INS_HEAD = 3'd1,
      OP_APPEND   = 3'd2,
      OP_INS_POS  = 3'd3,
      OP_DELETE   = 3'd4
   } op_type;

   typedef enum logic [STAT_W-1:0] {
      ST_DONE  = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      DSEL_ZERO = 2'd0,
      DSEL_RAM  = 2'd1,
      DSEL_ONES = 2'd2
   } dsel_type;

   typedef enum logic [2:0] {
      IDX_HOLD  = 3'd0,
      IDX_COUNT = 3'd1,
      IDX_POS   = 3'd2,
      IDX_DEC   = 3'd3,
      IDX_INC   = 3'd4
   } idx_op_type;

   typedef enum logic [1:0] {
      RD_POS  = 2'd0,
      RD_DOWN = 2'd1,
      RD_UP   = 2'd2
   } rd_sel_type;

   typedef enum logic {
      WR_SHIFT  = 1'b0,
      WR_INSERT = 1'b1
   } wr_sel_type;

   typedef enum logic [1:0] {
      CNT_HOLD = 2'd0,
      CNT_INC  = 2'd1,
      CNT_DEC  = 2'd2
   } cnt_op_type;

   typedef struct packed {
      logic       load_item;
      idx_op_type idx_op;
      logic       rd_en;
      rd_sel_type rd_sel;
      logic       wr_en;
      wr_sel_type wr_sel;
      cnt_op_type cnt_op;
      logic       rsp_load;
      dsel_type   rsp_dsel;
      status_type rsp_status;
   } cmd_type;

   typedef struct packed {
      op_type opc;
      logic   pos_lt_count;
      logic   pos_le_count;
      logic   full;
      logic   idx_gt_tgt;
      logic   idx_inc_lt_count;
      logic   rsp_busy;
   } stat_type;

endpackage

[rtl/ils_ram.sv]
module ils_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/ils_ctrl.sv]
module ils_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  ils_pkg::stat_type stat,
   output ils_pkg::cmd_type  cmd
);

   typedef enum logic [8:0] {
      S_IDLE      = 9'b000000001,
      S_DECIDE    = 9'b000000010,
      S_READ_WAIT = 9'b000000100,
      S_UP_RD     = 9'b000001000,
      S_UP_WR     = 9'b000010000,
      S_INS_WR    = 9'b000100000,
      S_DN_RD     = 9'b001000000,
      S_DN_WR     = 9'b010000000,
      S_RESPOND   = 9'b100000000
   } state_type;

   state_type              state_ff, state_in;
   ils_pkg::dsel_type      dsel_ff, dsel_in;
   ils_pkg::status_type    res_ff, res_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         dsel_ff  <= ils_pkg::DSEL_ZERO;
         res_ff   <= ils_pkg::ST_DONE;
      end else begin
         state_ff <= state_in;
         dsel_ff  <= dsel_in;
         res_ff   <= res_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in       = state_ff;
      dsel_in        = dsel_ff;
      res_in         = res_ff;
      cmd            = '0;
      cmd.idx_op     = ils_pkg::IDX_HOLD;
      cmd.rd_sel     = ils_pkg::RD_POS;
      cmd.wr_sel     = ils_pkg::WR_SHIFT;
      cmd.cnt_op     = ils_pkg::CNT_HOLD;
      cmd.rsp_dsel   = dsel_ff;
      cmd.rsp_status = res_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load_item = 1'b1;
               state_in      = S_DECIDE;
            end
         end
         S_DECIDE: begin
            dsel_in  = ils_pkg::DSEL_ZERO;
            res_in   = ils_pkg::ST_DONE;
            state_in = S_RESPOND;
            unique case (stat.opc)
               ils_pkg::OP_READ: begin
                  if (stat.pos_lt_count) begin
                     cmd.rd_en  = 1'b1;
                     cmd.rd_sel = ils_pkg::RD_POS;
                     dsel_in    = ils_pkg::DSEL_RAM;
                     state_in   = S_READ_WAIT;
                  end else begin
                     dsel_in = ils_pkg::DSEL_ONES;
                     res_in  = ils_pkg::ST_RANGE;
                  end
               end
               ils_pkg::OP_INS_HEAD, ils_pkg::OP_APPEND: begin
                  if (stat.full) begin
                     res_in = ils_pkg::ST_FULL;
                  end else begin
                     cmd.idx_op = ils_pkg::IDX_COUNT;
                     state_in   = S_UP_RD;
                  end
               end
               ils_pkg::OP_INS_POS: begin
                  // The range check takes precedence over the full check.
                  if (!stat.pos_le_count) begin
                     res_in = ils_pkg::ST_RANGE;
                  end else if (stat.full) begin
                     res_in = ils_pkg::ST_FULL;
                  end else begin
                     cmd.idx_op = ils_pkg::IDX_COUNT;
                     state_in   = S_UP_RD;
                  end
               end
               ils_pkg::OP_DELETE: begin
                  if (!stat.pos_lt_count) begin
                     res_in = ils_pkg::ST_RANGE;
                  end else begin
                     cmd.idx_op = ils_pkg::IDX_POS;
                     state_in   = S_DN_RD;
                  end
               end
               default: begin
                  state_in = S_RESPOND;
               end
            endcase
         end
         S_READ_WAIT: begin
            state_in = S_RESPOND;
         end
         S_UP_RD: begin
            if (stat.idx_gt_tgt) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = ils_pkg::RD_DOWN;
               state_in   = S_UP_WR;
            end else begin
               state_in = S_INS_WR;
            end
         end
         S_UP_WR: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = ils_pkg::WR_SHIFT;
            cmd.idx_op = ils_pkg::IDX_DEC;
            state_in   = S_UP_RD;
         end
         S_INS_WR: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = ils_pkg::WR_INSERT;
            cmd.cnt_op = ils_pkg::CNT_INC;
            state_in   = S_RESPOND;
         end
         S_DN_RD: begin
            if (stat.idx_inc_lt_count) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = ils_pkg::RD_UP;
               state_in   = S_DN_WR;
            end else begin
               cmd.cnt_op = ils_pkg::CNT_DEC;
               state_in   = S_RESPOND;
            end
         end
         S_DN_WR: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = ils_pkg::WR_SHIFT;
            cmd.idx_op = ils_pkg::IDX_INC;
            state_in   = S_DN_RD;
         end
         S_RESPOND: begin
            // Wait until the output register is free or being drained.
            if (!stat.rsp_busy) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

[rtl/ils_datapath.sv]
module ils_datapath (
   input  logic                       clock,
   input  logic                       reset,
   input  ils_pkg::cmd_type           cmd,
   output ils_pkg::stat_type          stat,
   input  logic [ils_pkg::REQ_W-1:0]  req_tdata,
   input  logic                       rsp_tready,
   output logic                       rsp_tvalid,
   output logic [ils_pkg::RSP_W-1:0]  rsp_tdata
);

   ils_pkg::op_type                  opc_ff, opc_in;
   logic [ils_pkg::POS_W-1:0]        pos_ff, pos_in;
   logic [ils_pkg::DATA_W-1:0]       din_ff, din_in;
   logic [ils_pkg::CNT_W-1:0]        count_ff, count_in;
   logic [ils_pkg::CNT_W-1:0]        idx_ff, idx_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [ils_pkg::DATA_W-1:0]       rsp_data_ff, rsp_data_in;
   ils_pkg::status_type              rsp_status_ff, rsp_status_in;
   logic [ils_pkg::CNTO_W-1:0]       rsp_count_ff, rsp_count_in;

   logic [ils_pkg::CMP_W-1:0]        pos_ext, cnt_ext, idx_ext, tgt_ext;
   logic [ils_pkg::CNT_W:0]          idx_up_wide;
   logic [ils_pkg::CNT_W-1:0]        idx_dn;
   logic [ils_pkg::ADDR_W-1:0]       rd_addr, wr_addr;
   logic [ils_pkg::DATA_W-1:0]       wr_data, ram_rdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      opc_ff        <= opc_in;
      pos_ff        <= pos_in;
      din_ff        <= din_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   // Latch the incoming word.
   always_comb begin
      opc_in = opc_ff;
      pos_in = pos_ff;
      din_in = din_ff;
      if (cmd.load_item) begin
         opc_in = ils_pkg::op_type'(req_tdata[ils_pkg::OP_W-1:0]);
         pos_in = req_tdata[ils_pkg::OP_W +: ils_pkg::POS_W];
         din_in = req_tdata[ils_pkg::OP_W + ils_pkg::POS_W +: ils_pkg::DATA_W];
      end
   end

   assign pos_ext = ils_pkg::CMP_W'(pos_ff);
   assign cnt_ext = ils_pkg::CMP_W'(count_ff);
   assign idx_ext = ils_pkg::CMP_W'(idx_ff);

   // Position where the new value lands for the three insert kinds.
   always_comb begin
      unique case (opc_ff)
         ils_pkg::OP_INS_HEAD: tgt_ext = '0;
         ils_pkg::OP_APPEND:   tgt_ext = cnt_ext;
         default:              tgt_ext = pos_ext;
      endcase
   end

   assign idx_up_wide = {1'b0, idx_ff} + (ils_pkg::CNT_W + 1)'(1);
   assign idx_dn      = idx_ff - ils_pkg::CNT_W'(1);

   always_comb begin
      stat.opc              = opc_ff;
      stat.pos_lt_count     = (pos_ext < cnt_ext);
      stat.pos_le_count     = (pos_ext <= cnt_ext);
      stat.full             = (count_ff == ils_pkg::CNT_W'(ils_pkg::CAPACITY));
      stat.idx_gt_tgt       = (idx_ext > tgt_ext);
      stat.idx_inc_lt_count = (idx_up_wide < {1'b0, count_ff});
      stat.rsp_busy         = rsp_valid_ff && !rsp_tready;
   end

   always_comb begin
      unique case (cmd.idx_op)
         ils_pkg::IDX_HOLD:  idx_in = idx_ff;
         ils_pkg::IDX_COUNT: idx_in = count_ff;
         ils_pkg::IDX_POS:   idx_in = ils_pkg::CNT_W'(pos_ext);
         ils_pkg::IDX_DEC:   idx_in = idx_dn;
         ils_pkg::IDX_INC:   idx_in = idx_up_wide[ils_pkg::CNT_W-1:0];
         default:            idx_in = idx_ff;
      endcase
   end

   always_comb begin
      unique case (cmd.cnt_op)
         ils_pkg::CNT_HOLD: count_in = count_ff;
         ils_pkg::CNT_INC:  count_in = count_ff + ils_pkg::CNT_W'(1);
         ils_pkg::CNT_DEC:  count_in = count_ff - ils_pkg::CNT_W'(1);
         default:           count_in = count_ff;
      endcase
   end

   always_comb begin
      unique case (cmd.rd_sel)
         ils_pkg::RD_POS:  rd_addr = pos_ext[ils_pkg::ADDR_W-1:0];
         ils_pkg::RD_DOWN: rd_addr = idx_dn[ils_pkg::ADDR_W-1:0];
         ils_pkg::RD_UP:   rd_addr = idx_up_wide[ils_pkg::ADDR_W-1:0];
         default:          rd_addr = pos_ext[ils_pkg::ADDR_W-1:0];
      endcase
   end

   // A shift moves the entry just read into the slot under the cursor.
   always_comb begin
      unique case (cmd.wr_sel)
         ils_pkg::WR_SHIFT: begin
            wr_addr = idx_ff[ils_pkg::ADDR_W-1:0];
            wr_data = ram_rdata;
         end
         ils_pkg::WR_INSERT: begin
            wr_addr = tgt_ext[ils_pkg::ADDR_W-1:0];
            wr_data = din_ff;
         end
         default: begin
            wr_addr = idx_ff[ils_pkg::ADDR_W-1:0];
            wr_data = ram_rdata;
         end
      endcase
   end

   ils_ram #(
      .WIDTH (ils_pkg::DATA_W),
      .DEPTH (ils_pkg::CAPACITY)
   ) u_entries (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_rdata)
   );

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = cmd.rsp_status;
         rsp_count_in  = ils_pkg::CNTO_W'(count_ff);
         unique case (cmd.rsp_dsel)
            ils_pkg::DSEL_ZERO: rsp_data_in = '0;
            ils_pkg::DSEL_RAM:  rsp_data_in = ram_rdata;
            ils_pkg::DSEL_ONES: rsp_data_in = '1;
            default:            rsp_data_in = '0;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = ils_pkg::RSP_W'({rsp_count_ff, rsp_status_ff, rsp_data_ff});

endmodule

[rtl/indexed_list_store.sv]
// Ordered list of up to ils_pkg::CAPACITY signed 32-bit values held in a RAM with one
// write port and one registered read port, with one response word for every request word.
// Requests are taken one at a time. With the output register free, a read steps through the
// decide, read-wait and respond states before its response goes valid. An insert at the head
// places the new value at position 0 and an append places it at count. Inserts and deletes
// move each entry behind the affected position by one slot, with a read through the RAM's
// registered read port and then a write. Refused operations (out of range or full) and
// unused opcodes respond straight from the decide state and leave the list unchanged. The
// controller goes back to idle as it loads the response, so the next request can be accepted
// in the same cycle that the response goes valid, even while that response still waits in
// the output register. A stalled response delays only the loading of the next response.
module indexed_list_store (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // opcode [2:0], position [9:3], data_in [41:10], zero fill above
   input  logic [ils_pkg::REQ_W-1:0] req_tdata,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // data_out [31:0], status [33:32], count_out [40:34], zero fill above
   output logic [ils_pkg::RSP_W-1:0] rsp_tdata
);

   ils_pkg::cmd_type  cmd;
   ils_pkg::stat_type stat;

   ils_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   ils_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_tdata  (req_tdata),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
